FILE: rtl/sbc_pkg.sv
// ----------------------------------------------------------------------------
// Swept box collision package
// Shared widths, time constants and normal codes of the swept box test.
// ----------------------------------------------------------------------------
package sbc_pkg;

	localparam int COORD_BITS_DEF = 24;
	localparam int FRAC_BITS_DEF  = 8;

	localparam int STEP_BITS  = 16;   // frame time, Q0.16
	localparam int FIX_BITS   = 16;   // fixed box edge, whole units
	localparam int FIXSZ_BITS = 15;   // fixed box size, whole units
	localparam int TIME_BITS  = 17;   // hit time, Q1.16
	localparam int NORM_BITS  = 2;
	localparam int QUO_BITS   = 32;   // quotient bits of one slab time
	localparam int SLAB_BITS  = QUO_BITS + 3;

	localparam logic signed [SLAB_BITS-1:0] T_CAP = SLAB_BITS'(64'h1_0000_0000);
	localparam logic signed [SLAB_BITS-1:0] T_INF = T_CAP + SLAB_BITS'(1);
	localparam logic signed [SLAB_BITS-1:0] T_ONE = SLAB_BITS'(65536);

	localparam logic signed [NORM_BITS-1:0] NORM_ZERO = 2'b00;
	localparam logic signed [NORM_BITS-1:0] NORM_POS  = 2'b01;
	localparam logic signed [NORM_BITS-1:0] NORM_NEG  = 2'b11;

endpackage

FILE: rtl/swept_box_collision.sv
// ----------------------------------------------------------------------------
// Swept box collision
// Slab test of a moving box swept along its velocity against a fixed box.
// ----------------------------------------------------------------------------
// Usage:
// One test enters on the s_ channel as a transfer of s_tdata and leaves as
// one transfer on the m_ channel, in order. s_tdata carries the moving box,
// the fixed box, the velocity and the frame time; m_tdata carries the hit
// flag, the hit time, the contact point and the axis normal. With no hit
// every result field is zero.
// Throughput is one test per cycle whenever s_tready is high.
// The four slab divisions run as a 32-stage restoring divider, one
// quotient bit per stage, which sets the depth of the pipeline.
// When m_tready is low while a result waits, the whole pipeline holds and
// s_tready drops; nothing is lost or repeated and it resumes on the next
// cycle with m_tready high.
// Reset (arst_n low) clears every valid bit at once; the block takes input
// in the first cycle after reset is released.
// ----------------------------------------------------------------------------
module swept_box_collision #(
	parameter int COORD_BITS = sbc_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = sbc_pkg::FRAC_BITS_DEF,
	localparam int IN_BITS  = 6 * COORD_BITS + 76,
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
	localparam int OUT_BITS = 2 * COORD_BITS + 22,
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// moving_x, moving_y, moving_w, moving_h, fixed_x, fixed_y, fixed_w,
	// fixed_h, vel_x, vel_y, step_time
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// hit, hit_time, contact_x, contact_y, normal_x, normal_y
	output logic [OUT_W-1:0] m_tdata
);
	import sbc_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int DW = C + STEP_BITS + 1;
	localparam int NW = ((C > FIX_BITS + FRAC_BITS) ? C : FIX_BITS + FRAC_BITS) + 2;
	localparam int QB = QUO_BITS;
	localparam int LO = DW / 2;
	localparam int MW = DW + TIME_BITS;
	localparam int CW = MW + 2;
	localparam int SW = SLAB_BITS;

	localparam int O_MX = 0;
	localparam int O_MY = C;
	localparam int O_MW = 2 * C;
	localparam int O_MH = 3 * C - 1;
	localparam int O_FX = 4 * C - 2;
	localparam int O_FY = O_FX + FIX_BITS;
	localparam int O_FW = O_FY + FIX_BITS;
	localparam int O_FH = O_FW + FIXSZ_BITS;
	localparam int O_VX = O_FH + FIXSZ_BITS;
	localparam int O_VY = O_VX + C;
	localparam int O_ST = O_VY + C;

	localparam logic signed [C-1:0] C_HI = {1'b0, {(C - 1){1'b1}}};
	localparam logic signed [C-1:0] C_LO = {1'b1, {(C - 1){1'b0}}};

	typedef struct packed {
		logic signed [C-1:0] mx;
		logic signed [C-1:0] my;
		logic [C-2:0]        mw;
		logic [C-2:0]        mh;
		logic [DW-1:0]       udx;
		logic [DW-1:0]       udy;
		logic                dnegx;
		logic                dnegy;
		logic                dzx;
		logic                dzy;
		logic                nnltx;
		logic                fngtx;
		logic                nnlty;
		logic                fngty;
		logic [3:0]          qneg;
		logic [3:0]          qzero;
		logic [3:0]          qbig;
	} side_t;

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// ---------------- stage 1: direction products and numerators
	logic signed [C-1:0]    in_mx, in_my, in_vx, in_vy;
	logic [C-2:0]           in_mw, in_mh;
	logic signed [FIX_BITS-1:0] in_fx, in_fy;
	logic [FIXSZ_BITS-1:0]  in_fw, in_fh;
	logic [STEP_BITS-1:0]   in_st;
	logic signed [NW-1:0]   fxe, fye, fxr, fyb;

	assign in_mx = s_tdata[O_MX +: C];
	assign in_my = s_tdata[O_MY +: C];
	assign in_mw = s_tdata[O_MW +: C - 1];
	assign in_mh = s_tdata[O_MH +: C - 1];
	assign in_fx = s_tdata[O_FX +: FIX_BITS];
	assign in_fy = s_tdata[O_FY +: FIX_BITS];
	assign in_fw = s_tdata[O_FW +: FIXSZ_BITS];
	assign in_fh = s_tdata[O_FH +: FIXSZ_BITS];
	assign in_vx = s_tdata[O_VX +: C];
	assign in_vy = s_tdata[O_VY +: C];
	assign in_st = s_tdata[O_ST +: STEP_BITS];

	assign fxe = NW'(in_fx) <<< FRAC_BITS;
	assign fye = NW'(in_fy) <<< FRAC_BITS;
	assign fxr = fxe + (NW'({1'b0, in_fw}) <<< FRAC_BITS);
	assign fyb = fye + (NW'({1'b0, in_fh}) <<< FRAC_BITS);

	logic                 v_s1;
	logic signed [DW-1:0] dx_s1, dy_s1;
	logic signed [NW-1:0] num_s1 [4];
	logic signed [C-1:0]  mx_s1, my_s1;
	logic [C-2:0]         mw_s1, mh_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1     <= DW'(in_vx * $signed({1'b0, in_st}));
			dy_s1     <= DW'(in_vy * $signed({1'b0, in_st}));
			num_s1[0] <= fxe - NW'(in_mx) - NW'({1'b0, in_mw});
			num_s1[1] <= fxr - NW'(in_mx);
			num_s1[2] <= fye - NW'(in_my) - NW'({1'b0, in_mh});
			num_s1[3] <= fyb - NW'(in_my);
			mx_s1     <= in_mx;
			my_s1     <= in_my;
			mw_s1     <= in_mw;
			mh_s1     <= in_mh;
		end
	end

	// ---------------- stage 2: magnitudes, signs and divider load
	logic [DW-1:0] s2_udx, s2_udy, s2_ud [4], s2_un [4];
	logic [NW-1:0] s2_an [4];
	side_t         s2_side;

	always_comb begin
		s2_udx = dx_s1[DW-1] ? DW'(-dx_s1) : DW'(dx_s1);
		s2_udy = dy_s1[DW-1] ? DW'(-dy_s1) : DW'(dy_s1);
		s2_side.mx    = mx_s1;
		s2_side.my    = my_s1;
		s2_side.mw    = mw_s1;
		s2_side.mh    = mh_s1;
		s2_side.udx   = s2_udx;
		s2_side.udy   = s2_udy;
		s2_side.dnegx = dx_s1[DW-1];
		s2_side.dnegy = dy_s1[DW-1];
		s2_side.dzx   = (dx_s1 == '0);
		s2_side.dzy   = (dy_s1 == '0);
		s2_side.nnltx = num_s1[0][NW-1];
		s2_side.fngtx = !num_s1[1][NW-1] && (num_s1[1] != '0);
		s2_side.nnlty = num_s1[2][NW-1];
		s2_side.fngty = !num_s1[3][NW-1] && (num_s1[3] != '0);
		for (int j = 0; j < 4; j++) begin
			s2_ud[j] = (j < 2) ? s2_udx : s2_udy;
			s2_an[j] = num_s1[j][NW-1] ? NW'(-num_s1[j]) : NW'(num_s1[j]);
			s2_un[j] = DW'(s2_an[j]);
			s2_side.qneg[j]  = num_s1[j][NW-1] ^ ((j < 2) ? dx_s1[DW-1] : dy_s1[DW-1]);
			s2_side.qzero[j] = (num_s1[j] == '0);
			s2_side.qbig[j]  = (s2_un[j] >= s2_ud[j]);
		end
	end

	// ---------------- divider: one quotient bit per stage, four lanes
	logic          dv_s [QB+1];
	side_t         dside_s [QB+1];
	logic [DW-1:0] dr_s [QB+1][4];
	logic [QB-1:0] dq_s [QB+1][4];
	logic [DW-1:0] dr_n [QB+1][4];
	logic [QB-1:0] dq_n [QB+1][4];

	always_comb begin
		logic [DW:0]   r2;
		logic [DW-1:0] ud;
		logic          ge;
		for (int k = 0; k <= QB; k++) begin
			for (int j = 0; j < 4; j++) begin
				dr_n[k][j] = '0;
				dq_n[k][j] = '0;
			end
		end
		for (int k = 1; k <= QB; k++) begin
			for (int j = 0; j < 4; j++) begin
				r2 = {dr_s[k-1][j], 1'b0};
				ud = (j < 2) ? dside_s[k-1].udx : dside_s[k-1].udy;
				ge = (r2 >= {1'b0, ud});
				dr_n[k][j] = ge ? DW'(r2 - {1'b0, ud}) : DW'(r2);
				dq_n[k][j] = {dq_s[k-1][j][QB-2:0], ge};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dside_s[0] <= s2_side;
			for (int j = 0; j < 4; j++) begin
				dr_s[0][j] <= s2_un[j];
				dq_s[0][j] <= '0;
			end
			for (int k = 1; k <= QB; k++) begin
				dside_s[k] <= dside_s[k-1];
				for (int j = 0; j < 4; j++) begin
					dr_s[k][j] <= dr_n[k][j];
					dq_s[k][j] <= dq_n[k][j];
				end
			end
		end
	end

	// ---------------- stage 35: slab times per axis, ordered near/far
	side_t                 dl;
	logic signed [SW-1:0]  sl [4];
	logic signed [SW-1:0]  s35_tnx, s35_tfx, s35_tny, s35_tfy;

	assign dl = dside_s[QB];

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			if (dl.qzero[j])
				sl[j] = '0;
			else if (dl.qbig[j])
				sl[j] = dl.qneg[j] ? -T_CAP : T_CAP;
			else if (dl.qneg[j])
				sl[j] = -(SW'(dq_s[QB][j]) + SW'(dr_s[QB][j] != '0));
			else
				sl[j] = SW'(dq_s[QB][j]);
		end
		if (dl.dzx) begin
			s35_tnx = -T_INF;
			s35_tfx = T_INF;
		end else if (sl[0] > sl[1]) begin
			s35_tnx = sl[1];
			s35_tfx = sl[0];
		end else begin
			s35_tnx = sl[0];
			s35_tfx = sl[1];
		end
		if (dl.dzy) begin
			s35_tny = -T_INF;
			s35_tfy = T_INF;
		end else if (sl[2] > sl[3]) begin
			s35_tny = sl[3];
			s35_tfy = sl[2];
		end else begin
			s35_tny = sl[2];
			s35_tfy = sl[3];
		end
	end

	logic                 v_s35, okx_s35, oky_s35, rayz_s35;
	logic signed [SW-1:0] tnx_s35, tfx_s35, tny_s35, tfy_s35;
	side_t                side_s35;

	always_ff @(posedge clk) begin
		if (en) begin
			tnx_s35  <= s35_tnx;
			tfx_s35  <= s35_tfx;
			tny_s35  <= s35_tny;
			tfy_s35  <= s35_tfy;
			okx_s35  <= !dl.dzx || (dl.nnltx && dl.fngtx);
			oky_s35  <= !dl.dzy || (dl.nnlty && dl.fngty);
			rayz_s35 <= dl.dzx && dl.dzy;
			side_s35 <= dl;
		end
	end

	// ---------------- stage 36: hit decision, time and normal
	logic signed [SW-1:0]        s36_tnear;
	logic                        s36_hit;
	logic signed [NORM_BITS-1:0] s36_nx, s36_ny;

	always_comb begin
		s36_tnear = (tnx_s35 > tny_s35) ? tnx_s35 : tny_s35;
		s36_hit = !rayz_s35 && okx_s35 && oky_s35 &&
			!(tnx_s35 > tfy_s35) && !(tny_s35 > tfx_s35) &&
			!tfx_s35[SW-1] && !tfy_s35[SW-1] && !(s36_tnear > T_ONE);
		s36_nx = NORM_ZERO;
		s36_ny = NORM_ZERO;
		// A tie between the two near times leaves the normal at zero.
		if (tnx_s35 > tny_s35)
			s36_nx = side_s35.dnegx ? NORM_POS : NORM_NEG;
		else if (tnx_s35 < tny_s35)
			s36_ny = side_s35.dnegy ? NORM_POS : NORM_NEG;
	end

	logic                        v_s36, hit_s36;
	logic [TIME_BITS-1:0]        t_s36;
	logic signed [NORM_BITS-1:0] nx_s36, ny_s36;
	side_t                       side_s36;

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s36  <= s36_hit;
			t_s36    <= s36_tnear[SW-1] ? '0 : s36_tnear[TIME_BITS-1:0];
			nx_s36   <= s36_nx;
			ny_s36   <= s36_ny;
			side_s36 <= side_s35;
		end
	end

	// ---------------- stage 37: travel products in two halves
	logic                        v_s37, hit_s37;
	logic [TIME_BITS-1:0]        t_s37;
	logic signed [NORM_BITS-1:0] nx_s37, ny_s37;
	side_t                       side_s37;
	logic [LO+TIME_BITS-1:0]     pxl_s37, pyl_s37;
	logic [DW-LO+TIME_BITS-1:0]  pxh_s37, pyh_s37;

	always_ff @(posedge clk) begin
		if (en) begin
			pxl_s37  <= side_s36.udx[LO-1:0] * t_s36;
			pxh_s37  <= side_s36.udx[DW-1:LO] * t_s36;
			pyl_s37  <= side_s36.udy[LO-1:0] * t_s36;
			pyh_s37  <= side_s36.udy[DW-1:LO] * t_s36;
			hit_s37  <= hit_s36;
			t_s37    <= t_s36;
			nx_s37   <= nx_s36;
			ny_s37   <= ny_s36;
			side_s37 <= side_s36;
		end
	end

	// ---------------- stage 38: full travel products
	logic                        v_s38, hit_s38;
	logic [TIME_BITS-1:0]        t_s38;
	logic signed [NORM_BITS-1:0] nx_s38, ny_s38;
	side_t                       side_s38;
	logic [MW-1:0]               mx_s38, my_s38;

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s38   <= (MW'(pxh_s37) << LO) + MW'(pxl_s37);
			my_s38   <= (MW'(pyh_s37) << LO) + MW'(pyl_s37);
			hit_s38  <= hit_s37;
			t_s38    <= t_s37;
			nx_s38   <= nx_s37;
			ny_s38   <= ny_s37;
			side_s38 <= side_s37;
		end
	end

	// ---------------- stage 39: contact point, rounded and saturated
	// The center plus travel is summed in units of 2^-32 and rounded half up.
	function automatic logic signed [C-1:0] contact_f(
		input logic signed [C-1:0] edge_v,
		input logic [C-2:0]        size_v,
		input logic                neg_v,
		input logic [MW-1:0]       trav_v
	);
		logic signed [CW-1:0]    sum;
		logic signed [CW-QB-1:0] whole;
		logic signed [C-1:0]     res;
		sum = (CW'(edge_v) <<< QB) + (CW'({1'b0, size_v}) <<< (QB - 1)) +
			(neg_v ? -CW'({1'b0, trav_v}) : CW'({1'b0, trav_v})) +
			(CW'(1) <<< (QB - 1));
		whole = sum[CW-1:QB];
		if (whole > (CW-QB)'(C_HI))
			res = C_HI;
		else if (whole < (CW-QB)'(C_LO))
			res = C_LO;
		else
			res = whole[C-1:0];
		return res;
	endfunction

	logic                        v_s39, hit_s39;
	logic [TIME_BITS-1:0]        t_s39;
	logic signed [C-1:0]         cx_s39, cy_s39;
	logic signed [NORM_BITS-1:0] nx_s39, ny_s39;

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s39 <= hit_s38;
			t_s39   <= hit_s38 ? t_s38 : '0;
			cx_s39  <= hit_s38 ? contact_f(side_s38.mx, side_s38.mw, side_s38.dnegx, mx_s38)
				: '0;
			cy_s39  <= hit_s38 ? contact_f(side_s38.my, side_s38.mh, side_s38.dnegy, my_s38)
				: '0;
			nx_s39  <= hit_s38 ? nx_s38 : NORM_ZERO;
			ny_s39  <= hit_s38 ? ny_s38 : NORM_ZERO;
		end
	end

	// ---------------- valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s35 <= 1'b0;
			v_s36 <= 1'b0;
			v_s37 <= 1'b0;
			v_s38 <= 1'b0;
			v_s39 <= 1'b0;
			for (int k = 0; k <= QB; k++)
				dv_s[k] <= 1'b0;
		end else if (en) begin
			v_s1    <= s_tvalid;
			dv_s[0] <= v_s1;
			for (int k = 1; k <= QB; k++)
				dv_s[k] <= dv_s[k-1];
			v_s35 <= dv_s[QB];
			v_s36 <= v_s35;
			v_s37 <= v_s36;
			v_s38 <= v_s37;
			v_s39 <= v_s38;
		end
	end

	assign m_tvalid = v_s39;
	assign m_tdata  = OUT_W'({ny_s39, nx_s39, cy_s39, cx_s39, t_s39, hit_s39});

	// ---------------- checks
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !hit_s39) |-> (t_s39 == '0 && cx_s39 == '0 && cy_s39 == '0 &&
		nx_s39 == NORM_ZERO && ny_s39 == NORM_ZERO))
		else $error("result fields not zero on a miss");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (t_s39 <= TIME_BITS'(T_ONE)))
		else $error("hit time beyond one step");

	a_one_normal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (nx_s39 == NORM_ZERO || ny_s39 == NORM_ZERO))
		else $error("normal set on both axes");

	a_normal_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (nx_s39 != 2'b10 && ny_s39 != 2'b10))
		else $error("normal out of range");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s38 && !en) |=> (v_s38 && $stable(mx_s38) && $stable(hit_s38)))
		else $error("pipeline moved during a stall");

endmodule

FILE: dv/swept_box_collision_checker.sv
// ----------------------------------------------------------------------------
// Swept box collision checker
// Watches both stream channels. For every input transfer it predicts the slab
// test result, then compares every output transfer field by field, in order.
// ----------------------------------------------------------------------------
module swept_box_collision_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	// moving_x, moving_y, moving_w, moving_h, fixed_x, fixed_y, fixed_w,
	// fixed_h, vel_x, vel_y, step_time
	input  logic [223:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	// hit, hit_time, contact_x, contact_y, normal_x, normal_y
	input  logic [71:0] m_tdata,
	output int          errors,
	output int          pending
);
	import sbc_pkg::*;

	localparam longint TCAP = 64'sd1 <<< 32;
	localparam longint TINF = TCAP + 1;

	typedef struct packed {
		logic signed [1:0]  normal_y;
		logic signed [1:0]  normal_x;
		logic signed [23:0] contact_y;
		logic signed [23:0] contact_x;
		logic [16:0]        hit_time;
		logic               hit;
	} hit_report_t;

	hit_report_t report_q[$];

	// floor(num * 2^32 / den), saturated to +-2^32
	function automatic longint slab_time_q16(longint num, longint den);
		bit neg;
		longint unsigned un, ud, q, r;
		neg = (num < 0) != (den < 0);
		un = num < 0 ? -num : num;
		ud = den < 0 ? -den : den;
		if (un == 0)
			return 0;
		if (un >= ud)
			return neg ? -TCAP : TCAP;
		q = (un << 32) / ud;
		r = (un << 32) % ud;
		if (neg) begin
			if (r != 0)
				q++;
			return -longint'(q);
		end
		return longint'(q);
	endfunction

	function automatic bit slab_span(longint nn, longint fn, longint d,
			output longint tn, output longint tf);
		longint a, b;
		if (d == 0) begin
			tn = -TINF;
			tf = TINF;
			return nn < 0 && fn > 0;
		end
		a = slab_time_q16(nn, d);
		b = slab_time_q16(fn, d);
		tn = a < b ? a : b;
		tf = a < b ? b : a;
		return 1'b1;
	endfunction

	// Moving center at time t, rounded half up and saturated.
	function automatic longint center_at(longint edge_v, longint size, longint d, longint t);
		longint unsigned ud, m;
		longint whole, frac, ip, fp, v;
		ud = d < 0 ? -d : d;
		m = ud * longint'(t);
		whole = longint'(m >> 32);
		frac = longint'(m & 64'hffff_ffff);
		ip = edge_v + (size >>> 1);
		fp = (size & 1) * (64'sd1 <<< 31);
		if (d < 0) begin
			ip -= whole;
			fp -= frac;
		end else begin
			ip += whole;
			fp += frac;
		end
		v = fp + (64'sd1 <<< 31);
		ip += v < 0 ? -1 : v / TCAP;
		if (ip > 8388607)
			ip = 8388607;
		if (ip < -8388608)
			ip = -8388608;
		return ip;
	endfunction

	function automatic hit_report_t predict_hit(logic [223:0] d);
		hit_report_t r;
		longint mx, my, mw, mh, fx, fy, fw, fh, dx, dy;
		longint nx, ny, fxt, fyt, tnear, t;
		r = '0;
		mx = longint'($signed(d[23:0]));
		my = longint'($signed(d[47:24]));
		mw = longint'(d[70:48]);
		mh = longint'(d[93:71]);
		fx = longint'($signed(d[109:94])) * 256;
		fy = longint'($signed(d[125:110])) * 256;
		fw = longint'(d[140:126]) * 256;
		fh = longint'(d[155:141]) * 256;
		dx = longint'($signed(d[179:156])) * longint'(d[219:204]);
		dy = longint'($signed(d[203:180])) * longint'(d[219:204]);
		if (dx == 0 && dy == 0)
			return r;
		if (!slab_span(fx - mx - mw, fx + fw - mx, dx, nx, fxt))
			return r;
		if (!slab_span(fy - my - mh, fy + fh - my, dy, ny, fyt))
			return r;
		if (nx > fyt || ny > fxt || fxt < 0 || fyt < 0)
			return r;
		tnear = nx > ny ? nx : ny;
		if (tnear > 65536)
			return r;
		t = tnear < 0 ? 0 : tnear;
		r.normal_x = NORM_ZERO;
		r.normal_y = NORM_ZERO;
		if (nx > ny)
			r.normal_x = dx < 0 ? NORM_POS : NORM_NEG;
		else if (nx < ny)
			r.normal_y = dy < 0 ? NORM_POS : NORM_NEG;
		r.hit = 1'b1;
		r.hit_time = t[16:0];
		r.contact_x = 24'(center_at(mx, mw, dx, t));
		r.contact_y = 24'(center_at(my, mh, dy, t));
		return r;
	endfunction

	function automatic int field_differs(string name, longint exp_v, longint act_v);
		if (exp_v == act_v)
			return 0;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp_v, act_v);
		return 1;
	endfunction

	always @(posedge clk) begin
		hit_report_t exp_r, act_r;
		int bad;
		if (!arst_n) begin
			errors = 0;
			report_q.delete();
		end else begin
			if (s_tvalid && s_tready)
				report_q.push_back(predict_hit(s_tdata));
			if (m_tvalid && m_tready) begin
				act_r = m_tdata[69:0];
				if (report_q.size() == 0) begin
					$display("%0t: result transfer with none expected, actual %h",
						$realtime, m_tdata);
					errors++;
				end else begin
					exp_r = report_q.pop_front();
					bad = 0;
					bad += field_differs("hit", exp_r.hit, act_r.hit);
					bad += field_differs("hit_time", exp_r.hit_time, act_r.hit_time);
					bad += field_differs("contact_x", exp_r.contact_x, act_r.contact_x);
					bad += field_differs("contact_y", exp_r.contact_y, act_r.contact_y);
					bad += field_differs("normal_x", exp_r.normal_x, act_r.normal_x);
					bad += field_differs("normal_y", exp_r.normal_y, act_r.normal_y);
					bad += field_differs("padding", 0, m_tdata[71:70]);
					if (bad != 0)
						errors++;
				end
			end
		end
		pending = report_q.size();
	end

endmodule

FILE: dv/swept_box_collision_test.sv
// ----------------------------------------------------------------------------
// Swept box collision test
// Drives directed corner cases and then mostly nearby box pairs with random
// stalls on both channels; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module swept_box_collision_test;

	localparam int CYCLE_LIMIT = 300000;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [223:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [71:0]  m_tdata;
	int           errors;
	int           pending;
	int           cycles = 0;
	bit           calm;

	swept_box_collision uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	swept_box_collision_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk)
		m_tready <= calm || ($urandom_range(99) >= 11);

	function automatic logic [223:0] pack_boxes(int mx, int my, int mw, int mh,
			int fx, int fy, int fw, int fh, int vx, int vy, int st);
		return {4'b0, 16'(st), 24'(vy), 24'(vx), 15'(fh), 15'(fw), 16'(fy), 16'(fx),
			23'(mh), 23'(mw), 24'(my), 24'(mx)};
	endfunction

	// Moving box placed up to about 60 units from the fixed box, with a random velocity.
	function automatic logic [223:0] near_pair();
		int fx, fy, fw, fh, mx, my, mw, mh, vx, vy, st;
		fx = $urandom_range(200) - 100;
		fy = $urandom_range(200) - 100;
		fw = $urandom_range(20);
		fh = $urandom_range(20);
		mw = $urandom_range(20 * 256);
		mh = $urandom_range(20 * 256);
		mx = (fx + $urandom_range(120) - 60) * 256 + $urandom_range(255);
		my = (fy + $urandom_range(120) - 60) * 256 + $urandom_range(255);
		vx = $urandom_range(8) == 0 ? 0 : int'($urandom_range(262144)) - 131072;
		vy = $urandom_range(8) == 0 ? 0 : int'($urandom_range(262144)) - 131072;
		st = $urandom_range(10) == 0 ? 0 : $urandom_range(65535);
		if ($urandom_range(3) == 0)
			vx = vx / 64 * 64;
		return pack_boxes(mx, my, mw, mh, fx, fy, fw, fh, vx, vy, st);
	endfunction

	task automatic send_test(logic [223:0] d);
		if (!calm && $urandom_range(99) < 11) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	initial begin
		logic [223:0] d;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		calm = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero ray: no velocity, then no frame time
		send_test(pack_boxes(0, 0, 256, 256, 10, 0, 5, 5, 0, 0, 65535));
		send_test(pack_boxes(0, 0, 256, 256, 10, 0, 5, 5, 2560, 0, 0));
		// head-on hits along each axis and both directions
		send_test(pack_boxes(0, 0, 256, 256, 10, 0, 5, 5, 5120, 0, 65535));
		send_test(pack_boxes(5120, 0, 256, 256, 10, 0, 5, 5, -5120, 0, 65535));
		send_test(pack_boxes(0, 0, 256, 256, 0, 10, 5, 5, 0, 5120, 65535));
		send_test(pack_boxes(0, 5120, 256, 256, 0, 10, 5, 5, 0, -5120, 65535));
		// zero x component inside the slab, on its edge and outside it
		send_test(pack_boxes(512, 0, 256, 256, 0, 10, 5, 5, 0, 5120, 65535));
		send_test(pack_boxes(1280, 0, 256, 256, 0, 10, 5, 5, 0, 5120, 65535));
		send_test(pack_boxes(5120, 0, 256, 256, 0, 10, 5, 5, 0, 5120, 65535));
		// exact diagonal gives equal near times
		send_test(pack_boxes(0, 0, 256, 256, 10, 10, 5, 5, 2560, 2560, 65535));
		// boxes already overlapping
		send_test(pack_boxes(2560, 2560, 512, 512, 10, 10, 5, 5, 256, -256, 32768));
		// overlapping with zero-size boxes and the ray leaving
		send_test(pack_boxes(2560, 2560, 0, 0, 10, 10, 0, 0, 256, 256, 65535));
		// falls short of the box
		send_test(pack_boxes(0, 0, 256, 256, 100, 0, 5, 5, 256, 0, 65535));
		// field extremes
		send_test(pack_boxes(-8388608, -8388608, 8388607, 8388607, -32768, -32768,
			32767, 32767, -8388608, -8388608, 65535));
		send_test(pack_boxes(8388607, 8388607, 8388607, 8388607, 32767, 32767,
			32767, 32767, 8388607, 8388607, 65535));
		send_test(pack_boxes(-8388608, 8388607, 0, 1, 32767, -32768, 0, 32767,
			8388607, -8388608, 1));
		send_test(pack_boxes(8388600, 0, 8388607, 256, 32767, 0, 32767, 5,
			8388607, 1, 65535));
		send_test(pack_boxes(-8388608, 0, 1, 1, -32768, -32768, 32767, 32767,
			-8388608, 0, 65535));
		send_test({4'b0, {220{1'b1}}});
		send_test('0);

		for (int i = 0; i < 1300; i++) begin
			calm = i >= 400 && i < 700;
			if (i == 900) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (pending != 0)
					@(posedge clk);
			end
			if ($urandom_range(99) < 15)
				d = {4'b0, 28'($urandom), $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom};
			else
				d = near_pair();
			send_test(d);
		end
		s_tvalid <= 1'b0;
		calm = 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: files.f
rtl/sbc_pkg.sv
rtl/swept_box_collision.sv
dv/swept_box_collision_checker.sv
dv/swept_box_collision_test.sv
